>>> design/dtp_pkg.sv
// shared constants, types and tables for direction_to_panorama_index
// no dependencies; imported by every module of the block
package dtp_pkg;

	localparam int MAX_WIDTH     = 8192;
	localparam int MAX_HEIGHT    = 4096;
	localparam int CORDIC_STAGES = 16;

	localparam int DIR_W  = 16;
	localparam int W_W    = 14;
	localparam int H_W    = 13;
	localparam int AREA_W = 26;
	localparam int IDX_W  = 25;
	localparam int RSQ_W  = 32;
	localparam int ROOT_W = 24;
	localparam int SQ_PAD = 2 * ROOT_W - RSQ_W;
	localparam int IN_SH  = 8;
	localparam int CW     = 27;
	localparam int ANG_W  = 20;
	localparam int CD_W   = 19;
	localparam int RN_W   = 20;
	localparam int COLN_W = 32;
	localparam int ROWN_W = 30;
	localparam int COLQ_W = 14;
	localparam int ROWQ_W = 13;
	localparam int ROW_W  = 14;
	localparam int TOT_W  = 32;

	localparam int TWO_PI_Q  = 411775;
	localparam int PI_Q      = 205887;
	localparam int PHI_MAX_Q = 102892;
	localparam int PHI_MIN_Q = -68728;
	localparam int COL_DIV   = TWO_PI_Q;
	localparam int ROW_DIV   = PHI_MAX_Q - PHI_MIN_Q;
	localparam int COL_SH    = 50;
	localparam int ROW_SH    = 47;
	localparam logic [COLN_W-1:0] COL_RECIP = COLN_W'((64'd1 << COL_SH) / COL_DIV);
	localparam logic [ROWN_W-1:0] ROW_RECIP = ROWN_W'((64'd1 << ROW_SH) / ROW_DIV);

	localparam int TAB_LEN = 24;
	localparam logic [16:0] ATAN_TAB [0:TAB_LEN-1] = '{
		17'd51472, 17'd30385, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
		17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
	};

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] x;
		logic signed [DIR_W-1:0] y;
		logic signed [DIR_W-1:0] z;
	} dtp_side_t;

	typedef struct packed {
		logic y_zero;
		logic x_neg;
		logic z_zero;
	} dtp_flags_t;

endpackage

>>> design/direction_to_panorama_index.sv
// top level: view direction to equirectangular panorama pixel index
// depends on dtp_pkg, dtp_isqrt, dtp_cordic, dtp_index
//
// usage:
//   a direction word (dir_x, dir_y, dir_z, signed q1.14) is taken at a rising
//   edge with start high and busy low; busy stays low, so a word may enter in
//   every cycle.
//   each word passes 50 register stages (2 squaring stages, 24 square root
//   stages, 16 cordic stages, 8 index stages) before done rises with its result.
//   pixel_index and wrapped_above_view are valid only while done is high.
//   throughput is one word per clock.
//   results leave in input order; the receiver cannot stall the pipeline.
//   pano_width and pano_height are written through cfg_valid / cfg_ready /
//   cfg_index / cfg_data; cfg_ready is always high. The user must write them
//   only while no word is in flight; the block itself does not enforce it.
//   reset clears all valid bits, so no result appears until words arrive, and
//   sets the panorama to 8192 x 4096.
module direction_to_panorama_index import dtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [DIR_W-1:0] dir_x,
	input  logic signed [DIR_W-1:0] dir_y,
	input  logic signed [DIR_W-1:0] dir_z,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [0:0]              cfg_index,
	input  logic [W_W-1:0]          cfg_data,
	output logic                    done,
	output logic [IDX_W-1:0]        pixel_index,
	output logic                    wrapped_above_view
);

	logic [W_W-1:0] width_q, w_eff;
	logic [H_W-1:0] height_q, h_eff;
	logic [AREA_W-1:0] area_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= W_W'(MAX_WIDTH);
			height_q <= H_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data[H_W-1:0];
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) w_eff = W_W'(1);
		else if (width_q > W_W'(MAX_WIDTH)) w_eff = W_W'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = H_W'(1);
		else if (height_q > H_W'(MAX_HEIGHT)) h_eff = H_W'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) area_q <= AREA_W'(MAX_WIDTH) * AREA_W'(MAX_HEIGHT);
		else area_q <= AREA_W'(w_eff) * AREA_W'(h_eff);
	end

	// squares and radial sum
	logic v_s1, v_s2;
	logic [RSQ_W-2:0] xsq_s1, ysq_s1;
	logic [RSQ_W-1:0] rsq_s2;
	dtp_side_t side_s1, side_s2;
	logic signed [RSQ_W-1:0] xsq_w, ysq_w;

	assign xsq_w = RSQ_W'(dir_x) * RSQ_W'(dir_x);
	assign ysq_w = RSQ_W'(dir_y) * RSQ_W'(dir_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		xsq_s1    <= xsq_w[RSQ_W-2:0];
		ysq_s1    <= ysq_w[RSQ_W-2:0];
		side_s1.x <= dir_x;
		side_s1.y <= dir_y;
		side_s1.z <= dir_z;
		rsq_s2    <= RSQ_W'(xsq_s1) + RSQ_W'(ysq_s1);
		side_s2   <= side_s1;
	end

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	dtp_side_t sq_side;

	dtp_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_rsq    (rsq_s2),
		.in_side   (side_s2),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// cordic lane setup
	logic signed [CW-1:0] xs, ys, tx, ty, px, py;
	dtp_flags_t flags;

	assign xs = {{(CW-DIR_W-IN_SH){sq_side.x[DIR_W-1]}}, sq_side.x, {IN_SH{1'b0}}};
	assign ys = {{(CW-DIR_W-IN_SH){sq_side.y[DIR_W-1]}}, sq_side.y, {IN_SH{1'b0}}};
	assign py = {{(CW-DIR_W-IN_SH){sq_side.z[DIR_W-1]}}, sq_side.z, {IN_SH{1'b0}}};
	assign px = $signed(CW'(sq_root));
	assign flags.y_zero = (sq_side.y == '0);
	assign flags.x_neg  = sq_side.x[DIR_W-1];
	assign flags.z_zero = (sq_side.z == '0);
	assign tx = flags.x_neg ? -xs : xs;
	assign ty = flags.x_neg ? -ys : ys;

	logic cd_valid;
	logic signed [ANG_W-1:0] cd_ta, cd_pa;
	dtp_flags_t cd_flags;

	dtp_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_valid),
		.in_tx     (tx),
		.in_ty     (ty),
		.in_px     (px),
		.in_py     (py),
		.in_flags  (flags),
		.out_valid (cd_valid),
		.out_ta    (cd_ta),
		.out_pa    (cd_pa),
		.out_flags (cd_flags)
	);

	dtp_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cd_valid),
		.in_ta     (cd_ta),
		.in_pa     (cd_pa),
		.in_flags  (cd_flags),
		.w         (w_eff),
		.h         (h_eff),
		.area      (area_q),
		.out_valid (done),
		.out_idx   (pixel_index),
		.out_wrap  (wrapped_above_view)
	);

endmodule

>>> design/dtp_isqrt.sv
// pipelined floor square root of rsq * 2^16, one result bit per stage
// depends on dtp_pkg
module dtp_isqrt import dtp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [RSQ_W-1:0]  in_rsq,
	input  dtp_side_t         in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output dtp_side_t         out_side
);

	logic              v_s    [0:ROOT_W-1];
	logic [RSQ_W-1:0]  rsq_s  [0:ROOT_W-1];
	logic [ROOT_W+1:0] rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];
	dtp_side_t         side_s [0:ROOT_W-1];

	logic              v_c    [0:ROOT_W-1];
	logic [RSQ_W-1:0]  rsq_c  [0:ROOT_W-1];
	logic [ROOT_W+1:0] rem_c  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_c [0:ROOT_W-1];
	dtp_side_t         side_c [0:ROOT_W-1];

	logic [ROOT_W+1:0] rem_n  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_n [0:ROOT_W-1];

	always_comb begin
		v_c[0]    = in_valid;
		rsq_c[0]  = in_rsq;
		rem_c[0]  = '0;
		root_c[0] = '0;
		side_c[0] = in_side;
		for (int i = 1; i < ROOT_W; i++) begin
			v_c[i]    = v_s[i-1];
			rsq_c[i]  = rsq_s[i-1];
			rem_c[i]  = rem_s[i-1];
			root_c[i] = root_s[i-1];
			side_c[i] = side_s[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < ROOT_W; i++) begin
			logic [2*ROOT_W-1:0] n_w;
			logic [ROOT_W+1:0]   trial;
			logic [ROOT_W+1:0]   test;
			n_w   = {rsq_c[i], {SQ_PAD{1'b0}}};
			trial = {rem_c[i][ROOT_W-1:0], n_w[2*(ROOT_W-1-i)+1 -: 2]};
			test  = {root_c[i], 2'b01};
			if (trial >= test) begin
				rem_n[i]  = trial - test;
				root_n[i] = {root_c[i][ROOT_W-2:0], 1'b1};
			end else begin
				rem_n[i]  = trial;
				root_n[i] = {root_c[i][ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROOT_W; i++) v_s[i] <= 1'b0;
		end else begin
			for (int i = 0; i < ROOT_W; i++) v_s[i] <= v_c[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ROOT_W; i++) begin
			rsq_s[i]  <= rsq_c[i];
			rem_s[i]  <= rem_n[i];
			root_s[i] <= root_n[i];
			side_s[i] <= side_c[i];
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_root  = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

>>> design/dtp_cordic.sv
// two-lane pipelined vectoring cordic, one micro-rotation per stage
// lane t gives the azimuth, lane p the elevation; depends on dtp_pkg
module dtp_cordic import dtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [CW-1:0]    in_tx,
	input  logic signed [CW-1:0]    in_ty,
	input  logic signed [CW-1:0]    in_px,
	input  logic signed [CW-1:0]    in_py,
	input  dtp_flags_t              in_flags,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] out_ta,
	output logic signed [ANG_W-1:0] out_pa,
	output dtp_flags_t              out_flags
);

	localparam int N = CORDIC_STAGES;

	logic                    v_s  [0:N-1];
	logic signed [CW-1:0]    tx_s [0:N-1];
	logic signed [CW-1:0]    ty_s [0:N-1];
	logic signed [CW-1:0]    px_s [0:N-1];
	logic signed [CW-1:0]    py_s [0:N-1];
	logic signed [ANG_W-1:0] ta_s [0:N-1];
	logic signed [ANG_W-1:0] pa_s [0:N-1];
	dtp_flags_t              fl_s [0:N-1];

	logic                    v_c  [0:N-1];
	logic signed [CW-1:0]    tx_c [0:N-1];
	logic signed [CW-1:0]    ty_c [0:N-1];
	logic signed [CW-1:0]    px_c [0:N-1];
	logic signed [CW-1:0]    py_c [0:N-1];
	logic signed [ANG_W-1:0] ta_c [0:N-1];
	logic signed [ANG_W-1:0] pa_c [0:N-1];
	dtp_flags_t              fl_c [0:N-1];

	always_comb begin
		v_c[0]  = in_valid;
		tx_c[0] = in_tx;
		ty_c[0] = in_ty;
		px_c[0] = in_px;
		py_c[0] = in_py;
		ta_c[0] = '0;
		pa_c[0] = '0;
		fl_c[0] = in_flags;
		for (int i = 1; i < N; i++) begin
			v_c[i]  = v_s[i-1];
			tx_c[i] = tx_s[i-1];
			ty_c[i] = ty_s[i-1];
			px_c[i] = px_s[i-1];
			py_c[i] = py_s[i-1];
			ta_c[i] = ta_s[i-1];
			pa_c[i] = pa_s[i-1];
			fl_c[i] = fl_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) v_s[i] <= 1'b0;
		end else begin
			for (int i = 0; i < N; i++) v_s[i] <= v_c[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			fl_s[i] <= fl_c[i];
			if (ty_c[i] < 0) begin
				tx_s[i] <= tx_c[i] - (ty_c[i] >>> i);
				ty_s[i] <= ty_c[i] + (tx_c[i] >>> i);
				ta_s[i] <= ta_c[i] - $signed(ANG_W'(ATAN_TAB[i]));
			end else begin
				tx_s[i] <= tx_c[i] + (ty_c[i] >>> i);
				ty_s[i] <= ty_c[i] - (tx_c[i] >>> i);
				ta_s[i] <= ta_c[i] + $signed(ANG_W'(ATAN_TAB[i]));
			end
			if (py_c[i] < 0) begin
				px_s[i] <= px_c[i] - (py_c[i] >>> i);
				py_s[i] <= py_c[i] + (px_c[i] >>> i);
				pa_s[i] <= pa_c[i] - $signed(ANG_W'(ATAN_TAB[i]));
			end else begin
				px_s[i] <= px_c[i] + (py_c[i] >>> i);
				py_s[i] <= py_c[i] - (px_c[i] >>> i);
				pa_s[i] <= pa_c[i] + $signed(ANG_W'(ATAN_TAB[i]));
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign out_ta    = ta_s[N-1];
	assign out_pa    = pa_s[N-1];
	assign out_flags = fl_s[N-1];

endmodule

>>> design/dtp_index.sv
// angle to pixel index: row and column scaling, constant divides, wrap
// eight register stages; depends on dtp_pkg
module dtp_index import dtp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [ANG_W-1:0] in_ta,
	input  logic signed [ANG_W-1:0] in_pa,
	input  dtp_flags_t              in_flags,
	input  logic [W_W-1:0]          w,
	input  logic [H_W-1:0]          h,
	input  logic [AREA_W-1:0]       area,
	output logic                    out_valid,
	output logic [IDX_W-1:0]        out_idx,
	output logic                    out_wrap
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	// s1: azimuth fix-up and numerators
	logic signed [ANG_W:0] th_base, th_wrap, th_clamp;
	logic signed [ANG_W-1:0] ph;
	logic [CD_W-1:0] cd_s1;
	logic signed [RN_W-1:0] rn_s1;

	always_comb begin
		if (in_flags.y_zero) begin
			th_base = in_flags.x_neg ? (ANG_W+1)'(PI_Q) : '0;
		end else if (in_flags.x_neg) begin
			th_base = (ANG_W+1)'(PI_Q) + (ANG_W+1)'(in_ta);
		end else begin
			th_base = (ANG_W+1)'(in_ta);
		end
		th_wrap = (th_base < 0) ? th_base + (ANG_W+1)'(TWO_PI_Q) : th_base;
		if (th_wrap < 0) begin
			th_clamp = '0;
		end else if (th_wrap > (ANG_W+1)'(TWO_PI_Q - 1)) begin
			th_clamp = (ANG_W+1)'(TWO_PI_Q - 1);
		end else begin
			th_clamp = th_wrap;
		end
		ph = in_flags.z_zero ? '0 : in_pa;
	end

	always_ff @(posedge clk) begin
		cd_s1 <= CD_W'((ANG_W+1)'(TWO_PI_Q) - th_clamp);
		rn_s1 <= RN_W'(PHI_MAX_Q) - RN_W'(ph);
	end

	// s2: scale by width and height
	logic [COLN_W-1:0] coln_s2, coln_s3, coln_s4;
	logic [ROWN_W-1:0] rown_s2, rown_s3, rown_s4;
	logic rneg_s2, rneg_s3, rneg_s4;
	logic [RN_W-2:0] rmag;

	assign rmag = rn_s1[RN_W-1] ? (RN_W-1)'(-rn_s1) : rn_s1[RN_W-2:0];

	always_ff @(posedge clk) begin
		coln_s2 <= COLN_W'(cd_s1) * COLN_W'(w);
		rown_s2 <= ROWN_W'(rmag) * ROWN_W'(h);
		rneg_s2 <= rn_s1[RN_W-1];
	end

	// s3: reciprocal multiply
	logic [2*COLN_W-1:0] colp;
	logic [2*ROWN_W-1:0] rowp;
	logic [COLQ_W-1:0] colq_s3, colq_s4;
	logic [ROWQ_W-1:0] rowq_s3, rowq_s4;

	assign colp = (2*COLN_W)'(coln_s2) * (2*COLN_W)'(COL_RECIP);
	assign rowp = (2*ROWN_W)'(rown_s2) * (2*ROWN_W)'(ROW_RECIP);

	always_ff @(posedge clk) begin
		colq_s3 <= colp[COL_SH +: COLQ_W];
		rowq_s3 <= rowp[ROW_SH +: ROWQ_W];
		coln_s3 <= coln_s2;
		rown_s3 <= rown_s2;
		rneg_s3 <= rneg_s2;
	end

	// s4: quotient times divisor
	logic [COLN_W-1:0] colm_s4;
	logic [ROWN_W-1:0] rowm_s4;

	always_ff @(posedge clk) begin
		colm_s4 <= COLN_W'(colq_s3) * COLN_W'(COL_DIV);
		rowm_s4 <= ROWN_W'(rowq_s3) * ROWN_W'(ROW_DIV);
		colq_s4 <= colq_s3;
		rowq_s4 <= rowq_s3;
		coln_s4 <= coln_s3;
		rown_s4 <= rown_s3;
		rneg_s4 <= rneg_s3;
	end

	// s5: one-step quotient correction
	logic [COLN_W-1:0] cr;
	logic [ROWN_W-1:0] rr;
	logic [COLQ_W-1:0] qa_s5, qa_s6;
	logic nz_s5, nz_s6;
	logic [ROWQ_W-1:0] rq;
	logic signed [ROW_W-1:0] row_s5;

	assign cr = coln_s4 - colm_s4;
	assign rr = rown_s4 - rowm_s4;
	assign rq = (rr >= ROWN_W'(ROW_DIV)) ? rowq_s4 + 1'b1 : rowq_s4;

	always_ff @(posedge clk) begin
		if (cr >= COLN_W'(COL_DIV)) begin
			qa_s5 <= colq_s4 + 1'b1;
			nz_s5 <= (cr != COLN_W'(COL_DIV));
		end else begin
			qa_s5 <= colq_s4;
			nz_s5 <= (cr != '0);
		end
		row_s5 <= rneg_s4 ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
	end

	// s6: row times width
	logic signed [TOT_W-1:0] k_s6;
	logic signed [TOT_W-1:0] row_ext, w_ext;

	assign row_ext = TOT_W'(row_s5);
	assign w_ext   = $signed(TOT_W'(w));

	always_ff @(posedge clk) begin
		k_s6  <= row_ext * w_ext;
		qa_s6 <= qa_s5;
		nz_s6 <= nz_s5;
	end

	// s7: truncating sum
	logic signed [TOT_W-1:0] f_sum, t_s7;

	assign f_sum = k_s6 + $signed(TOT_W'(qa_s6));

	always_ff @(posedge clk) begin
		t_s7 <= ((f_sum < 0) && nz_s6) ? f_sum + 1 : f_sum;
	end

	// s8: remainder by area
	logic signed [TOT_W-1:0] a_ext, t_p, t_m1, t_m2;
	logic [IDX_W-1:0] idx_s8;
	logic wrap_s8;

	assign a_ext = $signed(TOT_W'(area));
	assign t_p   = t_s7 + a_ext;
	assign t_m1  = t_s7 - a_ext;
	assign t_m2  = t_s7 - (a_ext <<< 1);

	always_ff @(posedge clk) begin
		if (t_s7 < 0) begin
			idx_s8  <= (t_p > 0) ? t_p[IDX_W-1:0] : '0;
			wrap_s8 <= (t_p > 0);
		end else if (t_m2 >= 0) begin
			idx_s8  <= t_m2[IDX_W-1:0];
			wrap_s8 <= 1'b0;
		end else if (t_m1 >= 0) begin
			idx_s8  <= t_m1[IDX_W-1:0];
			wrap_s8 <= 1'b0;
		end else begin
			idx_s8  <= t_s7[IDX_W-1:0];
			wrap_s8 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_idx   = idx_s8;
	assign out_wrap  = wrap_s8;

	a_col_quot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> (qa_s5 <= w))
		else $error("column quotient exceeds width");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (AREA_W'(idx_s8) < area))
		else $error("pixel index not below area");

	a_wrap_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && wrap_s8) |-> (idx_s8 != '0))
		else $error("wrapped index is zero");

endmodule

>>> sim/tb.sv
// testbench for direction_to_panorama_index: directed and random directions
// over several panorama sizes, each result checked against an in-bench predictor
// depends on dtp_pkg and the direction_to_panorama_index rtl
module tb;
	import dtp_pkg::*;

	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [DIR_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_reg_t cfg_index = REG_WIDTH;
	logic [W_W-1:0] cfg_data = '0;
	logic done;
	logic [IDX_W-1:0] pixel_index;
	logic wrapped_above_view;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic wrapped;
	} pixel_t;

	pixel_t pixel_q[$];
	logic [W_W-1:0] cur_width = 14'd8192;
	logic [H_W-1:0] cur_height = 13'd4096;
	int mismatches = 0;
	int cycles = 0;
	bit calm = 1'b0;

	direction_to_panorama_index i_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	function automatic longint vec_angle(longint x, longint y);
		longint ang, nx, ny;
		ang = 0;
		for (int i = 0; i < CORDIC_STAGES && i < TAB_LEN; i++) begin
			if (y < 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= longint'(ATAN_TAB[i]);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += longint'(ATAN_TAB[i]);
			end
			x = nx;
			y = ny;
		end
		return ang;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic pixel_t pano_pixel(logic signed [DIR_W-1:0] dx,
		logic signed [DIR_W-1:0] dy, logic signed [DIR_W-1:0] dz);
		longint x, y, z, w, h, theta, phi, row, total, idx, area;
		longint unsigned rsq;
		pixel_t p;
		x = longint'(dx) * 256;
		y = longint'(dy) * 256;
		z = longint'(dz) * 256;
		w = cur_width;
		h = cur_height;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		if (y == 0) theta = (x < 0) ? PI_Q : 0;
		else if (x < 0) theta = PI_Q + vec_angle(-x, -y);
		else theta = vec_angle(x, y);
		if (theta < 0) theta += TWO_PI_Q;
		if (theta < 0) theta = 0;
		if (theta > TWO_PI_Q - 1) theta = TWO_PI_Q - 1;
		if (dz == 0) begin
			phi = 0;
		end else begin
			rsq = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
			phi = vec_angle(longint'(root_floor(rsq << 16)), z);
		end
		row = ((PHI_MAX_Q - phi) * h) / (PHI_MAX_Q - PHI_MIN_Q);
		total = ((TWO_PI_Q - theta) * w + row * w * TWO_PI_Q) / TWO_PI_Q;
		area = w * h;
		idx = total % area;
		p.wrapped = 1'b0;
		if (idx < 0) begin
			idx += area;
			p.wrapped = 1'b1;
		end
		p.index = idx[IDX_W-1:0];
		return p;
	endfunction

	// result checker
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && done) begin
			if (pixel_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("tb: unexpected result word %0d", pixel_index);
			end else begin
				e = pixel_q.pop_front();
				if (e.index !== pixel_index || e.wrapped !== wrapped_above_view) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch exp idx %0d wrap %0b got idx %0d wrap %0b",
							e.index, e.wrapped, pixel_index, wrapped_above_view);
				end
			end
		end
	end

	task automatic send(logic signed [DIR_W-1:0] x, logic signed [DIR_W-1:0] y,
		logic signed [DIR_W-1:0] z);
		logic b;
		@(negedge clk);
		start <= 1'b1;
		dir_x <= x;
		dir_y <= y;
		dir_z <= z;
		do begin
			#1 b = busy;
			@(posedge clk);
		end while (b);
		pixel_q.push_back(pano_pixel(x, y, z));
	endtask

	task automatic maybe_idle();
		if (!calm && $urandom_range(99) < 33) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(3)) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [W_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (r == REG_WIDTH) cur_width = v;
		else cur_height = v[H_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_size(logic [W_W-1:0] w, logic [W_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	task automatic test_directed();
		send(16'sd32767, 16'sd0, 16'sd0);
		send(-16'sd32768, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd32767, 16'sd0);
		send(16'sd0, -16'sd32768, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd0);
		send(16'sd0, 16'sd0, 16'sd32767);
		send(16'sd0, 16'sd0, -16'sd32768);
		send(16'sd16384, 16'sd0, 16'sd16384);
		send(-16'sd16384, 16'sd0, -16'sd100);
		send(-16'sd32768, -16'sd32768, -16'sd32768);
		send(16'sd32767, 16'sd32767, 16'sd32767);
		send(-16'sd1, -16'sd1, 16'sd1);
		send(16'sd1, -16'sd1, -16'sd1);
		send(-16'sd32768, 16'sd1, 16'sd0);
		send(-16'sd32768, -16'sd1, 16'sd0);
		send(16'sd1, 16'sd0, 16'sd32767);
		send(16'sd11585, -16'sd11585, 16'sd16384);
		send(-16'sd11585, 16'sd11585, -16'sd16384);
		drain();
	endtask

	task automatic test_random(int n);
		logic signed [DIR_W-1:0] x, y, z;
		for (int k = 0; k < n; k++) begin
			calm = (k >= n / 3 && k < n / 2);
			x = DIR_W'($urandom);
			y = DIR_W'($urandom);
			z = DIR_W'($urandom);
			if ($urandom_range(3) == 0) begin
				x = $signed(x) >>> $urandom_range(15);
				y = $signed(y) >>> $urandom_range(15);
				z = $signed(z) >>> $urandom_range(15);
			end
			case ($urandom_range(9))
				0: y = '0;
				1: z = '0;
				2: x = '0;
				default: ;
			endcase
			send(x, y, z);
			maybe_idle();
		end
		calm = 1'b0;
		drain();
	endtask

	task automatic test_sizes();
		set_size(14'd1, 14'd1);
		test_random(30);
		set_size(14'd0, 14'd0);
		test_random(30);
		set_size(14'd16383, 14'd8191);
		test_random(30);
		set_size(14'd640, 14'd480);
		test_directed();
		test_random(60);
		set_size(W_W'($urandom_range(1, 8192)), W_W'($urandom_range(1, 4096)));
		test_random(60);
		set_size(14'd8192, 14'd4096);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(200);
		test_sizes();
		drain();
		if (mismatches == 0 && pixel_q.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> files.f
design/dtp_pkg.sv
design/dtp_isqrt.sv
design/dtp_cordic.sv
design/dtp_index.sv
design/direction_to_panorama_index.sv
sim/tb.sv
